### rtl/core/flpl_pkg.sv
// ============================================================================
// flpl_pkg
// Shared constants, types and helpers of the FIFO lot position ledger.
// ============================================================================
package flpl_pkg;

    // Queue and field sizes
    localparam int LOT_DEPTH  = 16;
    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 24;
    localparam int VAL_W      = 63;
    localparam int OUT_CNT_W  = 5;

    localparam int LOT_AW  = $clog2(LOT_DEPTH);
    localparam int CNT_W   = $clog2(LOT_DEPTH + 1);
    localparam int WALK_W  = CNT_W + 1;
    localparam int PROD_W  = PRICE_BITS + QTY_BITS;
    localparam int DIFF_W  = PRICE_BITS + 1;
    localparam int SPROD_W = DIFF_W + QTY_BITS + 1;

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(LOT_DEPTH);
    localparam logic [LOT_AW:0]   DEPTH_SUM = (LOT_AW + 1)'(LOT_DEPTH);

    // Saturation bounds of every cash and value sum
    localparam logic signed [VAL_W-1:0] VAL_MAX = 63'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 63'sh4000_0000_0000_0000;
    localparam logic signed [64:0]      SUM_MAX = 65'sh0_3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0]      SUM_MIN = -SUM_MAX - 65'sd1;

    // Request codes
    localparam logic CMD_TRADE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
    } t_lot;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    clip;
    } t_sat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRADE,
        S_DEBIT,
        S_CHECK,
        S_M_MUL,
        S_M_ADD,
        S_Q_WALK,
        S_Q_TOTAL,
        S_DONE
    } t_state;

    // Add two values within +-2^62 and clip to the 63-bit signed range
    function automatic t_sat sat_add(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        t_sat               r;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SUM_MAX) begin
            r.value = VAL_MAX;
            r.clip  = 1'b1;
        end else if (s < SUM_MIN) begin
            r.value = VAL_MIN;
            r.clip  = 1'b1;
        end else begin
            r.value = s[VAL_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    // Ring index add, both operands below LOT_DEPTH
    function automatic logic [LOT_AW-1:0] wrap_add(input logic [LOT_AW-1:0] a,
                                                   input logic [LOT_AW-1:0] b);
        logic [LOT_AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_SUM) begin
            s = s - DEPTH_SUM;
        end
        return s[LOT_AW-1:0];
    endfunction

endpackage

### rtl/core/flpl_in_if.sv
// ============================================================================
// flpl_in_if
// Request channel of the ledger: trade or query with valid/ready handshake.
// ============================================================================
interface flpl_in_if;
    import flpl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  command;
    logic                  side;
    logic [PRICE_BITS-1:0] price;
    logic [QTY_BITS-1:0]   quantity;
    logic [PRICE_BITS-1:0] bid_px;
    logic [PRICE_BITS-1:0] ask_px;

    modport source (
        output valid, command, side, price, quantity, bid_px, ask_px,
        input  ready
    );

    modport sink (
        input  valid, command, side, price, quantity, bid_px, ask_px,
        output ready
    );

endinterface

### rtl/core/flpl_out_if.sv
// ============================================================================
// flpl_out_if
// Result channel of the ledger: cash, valuation and queue status.
// ============================================================================
interface flpl_out_if;
    import flpl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [VAL_W-1:0]        cash_balance;
    logic [VAL_W-1:0]        unrealized_value;
    logic [VAL_W-1:0]        total_value;
    logic [OUT_CNT_W-1:0]    open_buy_lots;
    logic [OUT_CNT_W-1:0]    open_sell_lots;
    logic                    rejected;
    logic                    saturated;

    modport source (
        output valid, cash_balance, unrealized_value, total_value,
               open_buy_lots, open_sell_lots, rejected, saturated,
        input  ready
    );

    modport sink (
        input  valid, cash_balance, unrealized_value, total_value,
               open_buy_lots, open_sell_lots, rejected, saturated,
        output ready
    );

endinterface

### rtl/core/fifo_lot_position_ledger.sv
// A trade is enqueued, a buy then debits its cost, and each lot match is a multiply step then a cash credit.
// A trade into a full queue is rejected and goes from the enqueue step straight to the result.
// A query walks the open lots, buy lots before sell lots, and sums their values: one lot read per cycle.
// One request at a time; the next is taken once the result is registered.
// Sequencing is set by the read, match, write-back loop over the lot memories.
// Reset (synchronous, active low) clears counts, heads and cash; lot memories are not cleared.
// ============================================================================
// fifo_lot_position_ledger
// Two FIFO lot queues in synchronous memories with oldest-first matching,
// a saturating cash balance and a pipelined open-lot valuation walk.
// ============================================================================
module fifo_lot_position_ledger (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [flpl_pkg::VAL_W-1:0] i_cfg_wdata,
    flpl_in_if.sink                  i_req,
    flpl_out_if.source               o_rsp
);
    import flpl_pkg::*;

    // Control state
    t_state              r_state;
    t_state              n_state;
    logic [LOT_AW-1:0]   r_buy_head;
    logic [LOT_AW-1:0]   r_sell_head;
    logic [CNT_W-1:0]    r_buy_count;
    logic [CNT_W-1:0]    r_sell_count;
    logic signed [VAL_W-1:0] r_cash;
    logic [WALK_W-1:0]   r_walk;
    logic                r_p1_valid;
    logic                r_p1_sell;
    logic                r_p2_valid;
    logic                r_out_valid;

    // Request and working registers
    logic                  r_cmd;
    logic                  r_side;
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;
    logic [PRICE_BITS-1:0] r_bid;
    logic [PRICE_BITS-1:0] r_ask;
    logic                  r_rej;
    logic                  r_clip;
    logic signed [63:0]    r_prod;
    logic signed [VAL_W-1:0] r_acc;
    logic signed [VAL_W-1:0] r_total;

    // Result registers
    logic [VAL_W-1:0]     r_o_cash;
    logic [VAL_W-1:0]     r_o_unreal;
    logic [VAL_W-1:0]     r_o_total;
    logic [OUT_CNT_W-1:0] r_o_buy;
    logic [OUT_CNT_W-1:0] r_o_sell;
    logic                 r_o_rej;
    logic                 r_o_clip;

    // Lot memories
    t_lot r_buy_mem  [LOT_DEPTH];
    t_lot r_sell_mem [LOT_DEPTH];
    t_lot r_buy_q;
    t_lot r_sell_q;

    logic              w_buy_we;
    logic              w_sell_we;
    logic [LOT_AW-1:0] w_buy_waddr;
    logic [LOT_AW-1:0] w_sell_waddr;
    t_lot              w_buy_wdata;
    t_lot              w_sell_wdata;
    logic [LOT_AW-1:0] w_buy_raddr;
    logic [LOT_AW-1:0] w_sell_raddr;
    logic              w_in_ready;
    logic              w_in_take;
    logic              w_out_load;

    // Datapath terms
    logic              w_full;
    logic              w_b_ge;
    logic [QTY_BITS-1:0] w_min_q;
    logic [PROD_W-1:0] w_pq;
    logic [PROD_W-1:0] w_match_prod;
    logic [PROD_W-1:0] w_bid_val;
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [SPROD_W-1:0] w_sell_val;
    logic [WALK_W-1:0] w_lot_total;
    logic [WALK_W-1:0] w_sell_off;
    logic              w_walk_issue;
    logic              w_walk_done;
    t_sat              w_debit;
    t_sat              w_credit;
    t_sat              w_acc_sum;
    t_sat              w_total_sum;

    assign w_in_take  = i_req.valid && w_in_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Queue full test for the pending trade
    assign w_full = (r_side == SIDE_SELL) ? (r_sell_count == DEPTH_CNT)
                                          : (r_buy_count == DEPTH_CNT);

    // Match step: the smaller front quantity closes at the sell price
    assign w_b_ge       = r_buy_q.qty >= r_sell_q.qty;
    assign w_min_q      = w_b_ge ? r_sell_q.qty : r_buy_q.qty;
    assign w_match_prod = w_min_q * r_sell_q.price;
    assign w_pq         = r_price * r_qty;

    // Valuation terms of one lot
    assign w_bid_val  = r_bid * r_buy_q.qty;
    assign w_diff     = $signed({1'b0, r_sell_q.price}) - $signed({1'b0, r_ask});
    assign w_sell_val = w_diff * $signed({1'b0, r_sell_q.qty});

    // Walk control
    assign w_lot_total  = {1'b0, r_buy_count} + {1'b0, r_sell_count};
    assign w_sell_off   = r_walk - {1'b0, r_buy_count};
    assign w_walk_issue = r_walk < w_lot_total;
    assign w_walk_done  = !w_walk_issue && !r_p1_valid && !r_p2_valid;

    // Saturating sums
    assign w_debit     = sat_add({r_cash[VAL_W-1], r_cash}, 64'sd0 - r_prod);
    assign w_credit    = sat_add({r_cash[VAL_W-1], r_cash}, r_prod);
    assign w_acc_sum   = sat_add({r_acc[VAL_W-1], r_acc}, r_prod);
    assign w_total_sum = sat_add({r_cash[VAL_W-1], r_cash}, {r_acc[VAL_W-1], r_acc});

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_state = (i_req.command == CMD_QUERY) ? S_Q_WALK : S_TRADE;
                end
            end
            S_TRADE: begin
                if (w_full) begin
                    n_state = S_DONE;
                end else if (r_side == SIDE_BUY) begin
                    n_state = S_DEBIT;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_DEBIT:   n_state = S_CHECK;
            S_CHECK: begin
                if (r_buy_count != '0 && r_sell_count != '0) begin
                    n_state = S_M_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_MUL:   n_state = S_M_ADD;
            S_M_ADD:   n_state = S_CHECK;
            S_Q_WALK: begin
                if (w_walk_done) begin
                    n_state = S_Q_TOTAL;
                end
            end
            S_Q_TOTAL: n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Handshake and memory port control
    always_comb begin
        w_in_ready   = 1'b0;
        w_buy_we     = 1'b0;
        w_sell_we    = 1'b0;
        w_buy_waddr  = r_buy_head;
        w_sell_waddr = r_sell_head;
        w_buy_wdata  = r_buy_q;
        w_sell_wdata = r_sell_q;
        w_buy_raddr  = r_buy_head;
        w_sell_raddr = r_sell_head;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
            end
            S_TRADE: begin
                // enqueue at the tail of the chosen queue
                w_buy_waddr  = wrap_add(r_buy_head, r_buy_count[LOT_AW-1:0]);
                w_sell_waddr = wrap_add(r_sell_head, r_sell_count[LOT_AW-1:0]);
                w_buy_wdata  = '{price: r_price, qty: r_qty};
                w_sell_wdata = '{price: r_price, qty: r_qty};
                w_buy_we     = !w_full && (r_side == SIDE_BUY);
                w_sell_we    = !w_full && (r_side == SIDE_SELL);
            end
            S_M_MUL: begin
                // write back the remainder of the larger front lot
                w_buy_wdata  = '{price: r_buy_q.price, qty: r_buy_q.qty - r_sell_q.qty};
                w_sell_wdata = '{price: r_sell_q.price, qty: r_sell_q.qty - r_buy_q.qty};
                w_buy_we     = w_b_ge;
                w_sell_we    = !w_b_ge;
            end
            S_Q_WALK: begin
                w_buy_raddr  = wrap_add(r_buy_head, r_walk[LOT_AW-1:0]);
                w_sell_raddr = wrap_add(r_sell_head, w_sell_off[LOT_AW-1:0]);
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // Lot memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (w_buy_we) begin
            r_buy_mem[w_buy_waddr] <= w_buy_wdata;
        end
        r_buy_q <= r_buy_mem[w_buy_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_sell_we) begin
            r_sell_mem[w_sell_waddr] <= w_sell_wdata;
        end
        r_sell_q <= r_sell_mem[w_sell_raddr];
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_buy_head   <= '0;
            r_sell_head  <= '0;
            r_buy_count  <= '0;
            r_sell_count <= '0;
            r_cash       <= '0;
            r_walk       <= '0;
            r_p1_valid   <= 1'b0;
            r_p1_sell    <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // load opening cash
            if (i_cfg_we) begin
                r_cash <= i_cfg_wdata;
            end

            // hold the result until taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_cmd      <= i_req.command;
                        r_side     <= i_req.side;
                        r_price    <= i_req.price;
                        r_qty      <= i_req.quantity;
                        r_bid      <= i_req.bid_px;
                        r_ask      <= i_req.ask_px;
                        r_rej      <= 1'b0;
                        r_clip     <= 1'b0;
                        r_acc      <= '0;
                        r_walk     <= '0;
                        r_p1_valid <= 1'b0;
                        r_p2_valid <= 1'b0;
                    end
                end
                S_TRADE: begin
                    r_prod <= $signed({{(64 - PROD_W){1'b0}}, w_pq});
                    if (w_full) begin
                        r_rej <= 1'b1;
                    end else if (r_side == SIDE_BUY) begin
                        r_buy_count <= r_buy_count + CNT_W'(1);
                    end else begin
                        r_sell_count <= r_sell_count + CNT_W'(1);
                    end
                end
                S_DEBIT: begin
                    r_cash <= w_debit.value;
                    r_clip <= r_clip | w_debit.clip;
                end
                S_M_MUL: begin
                    r_prod <= $signed({{(64 - PROD_W){1'b0}}, w_match_prod});
                    if (w_b_ge) begin
                        // sell lot closes; buy lot closes too when emptied
                        r_sell_head  <= wrap_add(r_sell_head, LOT_AW'(1));
                        r_sell_count <= r_sell_count - CNT_W'(1);
                        if (r_buy_q.qty == r_sell_q.qty) begin
                            r_buy_head  <= wrap_add(r_buy_head, LOT_AW'(1));
                            r_buy_count <= r_buy_count - CNT_W'(1);
                        end
                    end else begin
                        r_buy_head  <= wrap_add(r_buy_head, LOT_AW'(1));
                        r_buy_count <= r_buy_count - CNT_W'(1);
                    end
                end
                S_M_ADD: begin
                    r_cash <= w_credit.value;
                    r_clip <= r_clip | w_credit.clip;
                end
                S_Q_WALK: begin
                    // issue one lot read per cycle: buy lots first, then sell lots
                    r_p1_valid <= w_walk_issue;
                    if (w_walk_issue) begin
                        r_walk    <= r_walk + WALK_W'(1);
                        r_p1_sell <= r_walk >= {1'b0, r_buy_count};
                    end
                    // value the lot that came back from memory
                    r_p2_valid <= r_p1_valid;
                    if (r_p1_valid) begin
                        if (r_p1_sell) begin
                            r_prod <= 64'(w_sell_val);
                        end else begin
                            r_prod <= $signed({{(64 - PROD_W){1'b0}}, w_bid_val});
                        end
                    end
                    // accumulate in lot order
                    if (r_p2_valid) begin
                        r_acc  <= w_acc_sum.value;
                        r_clip <= r_clip | w_acc_sum.clip;
                    end
                end
                S_Q_TOTAL: begin
                    r_total <= w_total_sum.value;
                    r_clip  <= r_clip | w_total_sum.clip;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_o_cash   <= r_cash;
                        r_o_unreal <= (r_cmd == CMD_QUERY) ? r_acc : '0;
                        r_o_total  <= (r_cmd == CMD_QUERY) ? r_total : r_cash;
                        r_o_buy    <= OUT_CNT_W'(r_buy_count);
                        r_o_sell   <= OUT_CNT_W'(r_sell_count);
                        r_o_rej    <= r_rej;
                        r_o_clip   <= r_clip;
                    end
                end
                default: begin
                    r_p1_valid <= 1'b0;
                    r_p2_valid <= 1'b0;
                end
            endcase
        end
    end

    // Drive the channels
    assign i_req.ready            = w_in_ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.cash_balance     = r_o_cash;
    assign o_rsp.unrealized_value = r_o_unreal;
    assign o_rsp.total_value      = r_o_total;
    assign o_rsp.open_buy_lots    = r_o_buy;
    assign o_rsp.open_sell_lots   = r_o_sell;
    assign o_rsp.rejected         = r_o_rej;
    assign o_rsp.saturated        = r_o_clip;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buy_count <= DEPTH_CNT) && (r_sell_count <= DEPTH_CNT))
        else $error("lot count above queue depth");

    a_one_side_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_buy_count == '0 || r_sell_count == '0))
        else $error("matching ended with both queues open");

    a_match_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_M_MUL) |=>
        ((r_buy_count < $past(r_buy_count)) || (r_sell_count < $past(r_sell_count))))
        else $error("match step closed no lot");

    a_query_keeps_queues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_WALK) |=>
        ($stable(r_buy_count) && $stable(r_sell_count) &&
         $stable(r_buy_head) && $stable(r_sell_head)))
        else $error("valuation walk changed the queues");

    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_valid || r_p2_valid) |-> (r_state == S_Q_WALK))
        else $error("valuation pipeline busy outside the walk");

endmodule

### tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the FIFO lot position ledger. A local lot book
// predicts every statement (cash, open lot value, lot counts, reject and
// clip flags) and the result monitor checks each statement in order. It runs
// directed requests first, then phases of random trading and queries under
// varying opening cash, with random gaps and stalls on both channels.
// ============================================================================
module tb_top;
    import flpl_pkg::*;

    localparam logic signed [63:0] CASH_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CASH_MIN = 64'shC000_0000_0000_0000;
    localparam int RANDOM_PHASES   = 19;
    localparam int PHASE_REQUESTS  = 100;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic                  command;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   quantity;
        logic [PRICE_BITS-1:0] bid_px;
        logic [PRICE_BITS-1:0] ask_px;
    } req_t;

    typedef struct packed {
        logic [VAL_W-1:0]     cash;
        logic [VAL_W-1:0]     unreal;
        logic [VAL_W-1:0]     total;
        logic [OUT_CNT_W-1:0] buys;
        logic [OUT_CNT_W-1:0] sells;
        logic                 rejected;
        logic                 saturated;
    } ledger_rsp_t;

    typedef enum int {FLOW_BALANCED, FLOW_BUYS, FLOW_SELLS, FLOW_QUERIES} t_flow;
    typedef enum int {TICKS_TIGHT, TICKS_WIDE, TICKS_EDGE} t_ticks;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [VAL_W-1:0] cfg_wdata;

    flpl_in_if  req_ch ();
    flpl_out_if rsp_ch ();

    fifo_lot_position_ledger dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Local lot book
    t_lot               buy_lots [LOT_DEPTH];
    t_lot               sell_lots[LOT_DEPTH];
    int unsigned        buy_front;
    int unsigned        buy_open;
    int unsigned        sell_front;
    int unsigned        sell_open;
    logic signed [63:0] cash_book;

    ledger_rsp_t statements_due[$];
    int          faults;

    // Idling controls
    bit src_gaps;
    bit sink_stalls;
    int hold_len;
    int hold_seq;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [63:0] clip_add(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    inout bit hit);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > 65'(CASH_MAX)) begin
            hit = 1'b1;
            return CASH_MAX;
        end else if (s < 65'(CASH_MIN)) begin
            hit = 1'b1;
            return CASH_MIN;
        end
        return s[63:0];
    endfunction

    // Close front lots oldest first until one side runs empty
    function automatic void close_matches(inout bit hit);
        t_lot        b;
        t_lot        s;
        logic [63:0] credit;
        while (buy_open != 0 && sell_open != 0) begin
            b = buy_lots[buy_front];
            s = sell_lots[sell_front];
            if (b.qty >= s.qty) begin
                credit = 64'(s.qty) * 64'(s.price);
                cash_book = clip_add(cash_book, $signed(credit), hit);
                buy_lots[buy_front].qty = b.qty - s.qty;
                sell_front = (sell_front + 1) % LOT_DEPTH;
                sell_open--;
                if (buy_lots[buy_front].qty == 0) begin
                    buy_front = (buy_front + 1) % LOT_DEPTH;
                    buy_open--;
                end
            end else begin
                credit = 64'(b.qty) * 64'(s.price);
                cash_book = clip_add(cash_book, $signed(credit), hit);
                sell_lots[sell_front].qty = s.qty - b.qty;
                buy_front = (buy_front + 1) % LOT_DEPTH;
                buy_open--;
            end
        end
    endfunction

    // Mark every open lot: buys at the bid, sells against the ask
    function automatic logic signed [63:0] open_lot_value(input logic [PRICE_BITS-1:0] bid,
                                                          input logic [PRICE_BITS-1:0] ask,
                                                          inout bit hit);
        logic signed [63:0] acc;
        logic signed [63:0] diff;
        logic [63:0]        mark;
        t_lot               l;
        acc = 0;
        for (int unsigned k = 0; k < buy_open; k++) begin
            l = buy_lots[(buy_front + k) % LOT_DEPTH];
            mark = 64'(bid) * 64'(l.qty);
            acc = clip_add(acc, $signed(mark), hit);
        end
        for (int unsigned k = 0; k < sell_open; k++) begin
            l = sell_lots[(sell_front + k) % LOT_DEPTH];
            diff = $signed({32'd0, l.price}) - $signed({32'd0, ask});
            acc = clip_add(acc, diff * $signed({40'd0, l.qty}), hit);
        end
        return acc;
    endfunction

    // Apply one request to the lot book and return the statement it yields
    function automatic ledger_rsp_t ledger_after(input req_t r);
        ledger_rsp_t        st;
        bit                 hit;
        bit                 rej;
        logic signed [63:0] unreal;
        logic signed [63:0] total;
        logic [63:0]        debit;
        hit = 1'b0;
        rej = 1'b0;
        unreal = 0;
        if (r.command == CMD_TRADE) begin
            if (r.side == SIDE_BUY) begin
                if (buy_open >= LOT_DEPTH) begin
                    rej = 1'b1;
                end else begin
                    buy_lots[(buy_front + buy_open) % LOT_DEPTH] = t_lot'{r.price, r.quantity};
                    buy_open++;
                    debit = 64'(r.price) * 64'(r.quantity);
                    cash_book = clip_add(cash_book, -$signed(debit), hit);
                end
            end else begin
                if (sell_open >= LOT_DEPTH) begin
                    rej = 1'b1;
                end else begin
                    sell_lots[(sell_front + sell_open) % LOT_DEPTH] =
                        t_lot'{r.price, r.quantity};
                    sell_open++;
                end
            end
            if (!rej) begin
                close_matches(hit);
            end
            total = cash_book;
        end else begin
            unreal = open_lot_value(r.bid_px, r.ask_px, hit);
            total = clip_add(cash_book, unreal, hit);
        end
        st.cash      = cash_book[VAL_W-1:0];
        st.unreal    = unreal[VAL_W-1:0];
        st.total     = total[VAL_W-1:0];
        st.buys      = OUT_CNT_W'(buy_open);
        st.sells     = OUT_CNT_W'(sell_open);
        st.rejected  = rej;
        st.saturated = hit;
        return st;
    endfunction

    function automatic logic [PRICE_BITS-1:0] draw_price(input t_ticks ticks);
        case (ticks)
            TICKS_TIGHT: return PRICE_BITS'(1000 + $urandom_range(0, 15));
            TICKS_WIDE:  return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return PRICE_BITS'(1);
                    2:       return '1;
                    3:       return {{(PRICE_BITS-1){1'b1}}, 1'b0};
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic logic [QTY_BITS-1:0] draw_qty(input t_ticks ticks);
        case (ticks)
            TICKS_TIGHT: return QTY_BITS'($urandom_range(0, 20));
            TICKS_WIDE:  return QTY_BITS'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return QTY_BITS'(1);
                    2:       return '1;
                    default: return QTY_BITS'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic req_t draw_request(input t_flow flow, input t_ticks ticks);
        req_t r;
        int   buy_pct;
        int   query_pct;
        r.price    = draw_price(ticks);
        r.quantity = draw_qty(ticks);
        r.bid_px   = draw_price(ticks);
        r.ask_px   = draw_price(ticks);
        r.side     = 1'($urandom_range(0, 1));
        case (flow)
            FLOW_BUYS: begin
                buy_pct = 85;
                query_pct = 10;
            end
            FLOW_SELLS: begin
                buy_pct = 15;
                query_pct = 10;
            end
            FLOW_QUERIES: begin
                buy_pct = 50;
                query_pct = 50;
            end
            default: begin
                buy_pct = 50;
                query_pct = 15;
            end
        endcase
        if ($urandom_range(0, 99) < query_pct) begin
            r.command = CMD_QUERY;
        end else begin
            r.command = CMD_TRADE;
            r.side = ($urandom_range(0, 99) < buy_pct) ? SIDE_BUY : SIDE_SELL;
        end
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] draw_opening_cash();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return CASH_MAX[VAL_W-1:0];
            2:       return CASH_MIN[VAL_W-1:0];
            3:       return VAL_W'($signed(64'($urandom_range(0, 2000000))) - 64'sd1000000);
            default: return raw[VAL_W-1:0];
        endcase
    endfunction

    function automatic req_t trade(input logic side, input logic [PRICE_BITS-1:0] price,
                                   input logic [QTY_BITS-1:0] qty);
        return req_t'{CMD_TRADE, side, price, qty, $urandom, $urandom};
    endfunction

    function automatic req_t query(input logic [PRICE_BITS-1:0] bid,
                                   input logic [PRICE_BITS-1:0] ask);
        return req_t'{CMD_QUERY, 1'($urandom_range(0, 1)), $urandom,
                      QTY_BITS'($urandom), bid, ask};
    endfunction

    // Offer one request, book it on acceptance, then idle for a random gap
    task automatic post_request(input req_t r);
        int gap;
        req_ch.valid    <= 1'b1;
        req_ch.command  <= r.command;
        req_ch.side     <= r.side;
        req_ch.price    <= r.price;
        req_ch.quantity <= r.quantity;
        req_ch.bid_px   <= r.bid_px;
        req_ch.ask_px   <= r.ask_px;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        statements_due = {statements_due, ledger_after(r)};
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every statement is back
    task automatic settle_statements(input int tail);
        req_ch.valid <= 1'b0;
        while (statements_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_opening_cash(input logic [VAL_W-1:0] v);
        settle_statements(4);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cash_book = $signed({v[VAL_W-1], v});
        cfg_we <= 1'b0;
    endtask

    task automatic test_empty_query();
        post_request(query('1, '1));
    endtask

    task automatic test_field_extremes();
        post_request(trade(SIDE_BUY, '1, '1));
        post_request(query('1, '0));
        post_request(trade(SIDE_SELL, '1, '1));
        post_request(trade(SIDE_SELL, '0, '0));
        post_request(query('0, '1));
    endtask

    // Zero lots close nothing but leave when they meet the other side
    task automatic test_zero_quantity();
        post_request(trade(SIDE_BUY, PRICE_BITS'(5), '0));
        post_request(trade(SIDE_BUY, PRICE_BITS'(7), '0));
        post_request(trade(SIDE_SELL, PRICE_BITS'(9), QTY_BITS'(3)));
    endtask

    task automatic test_saturation();
        write_opening_cash(CASH_MIN[VAL_W-1:0]);
        post_request(trade(SIDE_BUY, '1, '1));
        write_opening_cash(CASH_MAX[VAL_W-1:0]);
        post_request(trade(SIDE_SELL, '1, '1));
        post_request(query('0, '0));
    endtask

    // Push LOT_DEPTH + 1 sell trades so the sell queue fills and the trades past it are rejected
    task automatic test_queue_full();
        for (int n = 0; n < LOT_DEPTH + 1; n++) begin
            post_request(trade(SIDE_SELL, draw_price(TICKS_TIGHT), draw_qty(TICKS_TIGHT)));
        end
    endtask

    task automatic test_random_trading();
        t_flow  flow;
        t_ticks ticks;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_opening_cash(draw_opening_cash());
            flow  = t_flow'($urandom_range(0, 3));
            ticks = t_ticks'($urandom_range(0, 2));
            src_gaps    = (p % 4 != 1);
            sink_stalls <= (p % 4 != 2);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                post_request(draw_request(flow, ticks));
            end
        end
        src_gaps = 1'b1;
        sink_stalls <= 1'b1;
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_backpressure();
        settle_statements(4);
        src_gaps = 1'b0;
        hold_len <= 400;
        hold_seq <= hold_seq + 1;
        for (int n = 0; n < 12; n++) begin
            post_request(draw_request(FLOW_BALANCED, TICKS_TIGHT));
        end
        src_gaps = 1'b1;
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++) begin
            post_request(draw_request(FLOW_BALANCED, TICKS_EDGE));
        end
        settle_statements(0);
        for (int n = 0; n < 20; n++) begin
            post_request(draw_request(FLOW_QUERIES, TICKS_WIDE));
        end
    endtask

    // Result ready: random stalls plus the long hold-off on request
    initial begin : drive_result_ready
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall_left = pick_gap();
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Check each statement against the oldest one due
    always @(posedge i_clk) begin : check_statements
        ledger_rsp_t seen;
        ledger_rsp_t due;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.cash_balance, rsp_ch.unrealized_value, rsp_ch.total_value,
                     rsp_ch.open_buy_lots, rsp_ch.open_sell_lots, rsp_ch.rejected,
                     rsp_ch.saturated};
            if (statements_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS) begin
                    $display("unexpected statement: cash %0d total %0d",
                             $signed(seen.cash), $signed(seen.total));
                end
            end else begin
                due = statements_due[0];
                statements_due.delete(0);
                if (seen !== due) begin
                    faults++;
                    if (faults <= MAX_REPORTS) begin
                        $write("mismatch expected: cash %0d unreal %0d total %0d ",
                               $signed(due.cash), $signed(due.unreal), $signed(due.total));
                        $display("buys %0d sells %0d rej %0b sat %0b",
                                 due.buys, due.sells, due.rejected, due.saturated);
                        $write("         actual:   cash %0d unreal %0d total %0d ",
                               $signed(seen.cash), $signed(seen.unreal), $signed(seen.total));
                        $display("buys %0d sells %0d rej %0b sat %0b",
                                 seen.buys, seen.sells, seen.rejected, seen.saturated);
                    end
                end
            end
        end
    end

    initial begin
        faults      = 0;
        buy_front   = 0;
        buy_open    = 0;
        sell_front  = 0;
        sell_open   = 0;
        cash_book   = 0;
        src_gaps    = 1'b1;
        sink_stalls <= 1'b1;
        hold_len    <= 0;
        hold_seq    <= 0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_wdata       <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.command  <= CMD_TRADE;
        req_ch.side     <= SIDE_BUY;
        req_ch.price    <= '0;
        req_ch.quantity <= '0;
        req_ch.bid_px   <= '0;
        req_ch.ask_px   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_query();
        test_field_extremes();
        test_zero_quantity();
        test_saturation();
        test_queue_full();
        test_random_trading();
        test_backpressure();
        test_drain_pause();

        settle_statements(60);
        if (faults == 0 && statements_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/flpl_pkg.sv
rtl/core/flpl_in_if.sv
rtl/core/flpl_out_if.sv
rtl/core/fifo_lot_position_ledger.sv
tb/tb_top.sv
